[rtl/dda_pkg.sv]
// ---------------------------------------------------------------------------
// dda_pkg
// Shared types, default sizes and the control program of the DDA line
// rasterizer sequencer.
// ---------------------------------------------------------------------------
package dda_pkg;

  // Default sizes
  localparam int COORD_BITS_DEF    = 6;
  localparam int FRACTION_BITS_DEF = 16;

  // Program counter and program steps
  localparam int PC_BITS = 3;
  typedef logic [PC_BITS-1:0] pc_t;

  localparam pc_t PC_LATCH     = 3'd0;
  localparam pc_t PC_CHECK     = 3'd1;
  localparam pc_t PC_DIV_STEP  = 3'd2;
  localparam pc_t PC_DIV_STORE = 3'd3;
  localparam pc_t PC_EMIT      = 3'd4;

  // Datapath operation of one step
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LATCH,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_EMIT
  } op_t;

  // Jump condition of one step
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_BEAT,
    COND_ZERO_LEN,
    COND_DIV_DONE,
    COND_LAST_OUT
  } cond_t;

  // Control word: take the jump when the condition holds, else hold or fall through
  typedef struct packed {
    op_t   op;
    cond_t cond;
    logic  hold;
    pc_t   target;
  } uword_t;

  // Control program
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, hold: 1'b0, target: PC_LATCH};
    unique case (pc)
      PC_LATCH:     w = '{op: OP_LATCH,     cond: COND_IN_BEAT,  hold: 1'b1,
                          target: PC_CHECK};
      PC_CHECK:     w = '{op: OP_NOP,       cond: COND_ZERO_LEN, hold: 1'b0,
                          target: PC_EMIT};
      PC_DIV_STEP:  w = '{op: OP_DIV_STEP,  cond: COND_DIV_DONE, hold: 1'b1,
                          target: PC_DIV_STORE};
      PC_DIV_STORE: w = '{op: OP_DIV_STORE, cond: COND_ALWAYS,   hold: 1'b0,
                          target: PC_EMIT};
      PC_EMIT:      w = '{op: OP_EMIT,      cond: COND_LAST_OUT, hold: 1'b1,
                          target: PC_LATCH};
      default:      w = '{op: OP_NOP,       cond: COND_ALWAYS,   hold: 1'b0,
                          target: PC_LATCH};
    endcase
    return w;
  endfunction

endpackage

[rtl/dda_if.sv]
// ---------------------------------------------------------------------------
// dda_if
// Valid/ready channels of the DDA line rasterizer: segment in, pixel out.
// ---------------------------------------------------------------------------

// Segment channel
interface dda_seg_if #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;

  modport source (output valid, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, x_start, y_start, x_end, y_end, output ready);
endinterface

// Pixel channel
interface dda_pix_if #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  last_pixel;

  modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

[rtl/dda_line_rasterizer.sv]
// ---------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer: one segment in, step+1 rounded pixels out, the last
// one marked. A small control program steps a divider and accumulator pair.
// ---------------------------------------------------------------------------
//
//   channel  dir  payload                           beat
//   seg      in   x_start, y_start, x_end, y_end    one segment
//   pix      out  pixel_x, pixel_y, last_pixel      one pixel
//
// The restoring divider works one quotient bit per cycle for x and y side by
//   side; a zero-length segment skips it and goes straight to the emit step.
// Pixels go out one per cycle while pix is ready, through a single output register.
// Reset clears the program counter and the output valid; no clearing pass.
// A stall on pix holds the emit step; seg is taken only at the latch step,
//   also while the last pixel of the previous segment still waits.
module dda_line_rasterizer #(
  parameter int COORD_BITS    = dda_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = dda_pkg::FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  dda_seg_if.sink   seg,
  dda_pix_if.source pix
);
  import dda_pkg::*;

  localparam int DW        = COORD_BITS + FRACTION_BITS;  // dividend width
  localparam int ACC_W     = COORD_BITS + FRACTION_BITS;
  localparam int INC_W     = FRACTION_BITS + 2;
  localparam int DIV_CNT_W = $clog2(DW);

  // Sequencer
  pc_t    pc;
  pc_t    pc_next;
  uword_t uw;
  logic   cond_true;

  // Datapath registers
  logic [COORD_BITS-1:0]   steps;
  logic                    neg_x;
  logic                    neg_y;
  logic [DW-1:0]           dvd_x;
  logic [DW-1:0]           dvd_y;
  logic [COORD_BITS-1:0]   rem_x;
  logic [COORD_BITS-1:0]   rem_y;
  logic [DIV_CNT_W-1:0]    div_cnt;
  logic signed [INC_W-1:0] inc_x;
  logic signed [INC_W-1:0] inc_y;
  logic [ACC_W-1:0]        acc_x;
  logic [ACC_W-1:0]        acc_y;
  logic [COORD_BITS-1:0]   count;
  logic                    out_valid;
  logic [COORD_BITS-1:0]   out_x;
  logic [COORD_BITS-1:0]   out_y;
  logic                    out_last;

  // Combinational datapath values
  logic                    in_beat;
  logic                    emit_fire;
  logic                    last_out;
  logic [COORD_BITS-1:0]   adx;
  logic [COORD_BITS-1:0]   ady;
  logic [COORD_BITS:0]     trial_x;
  logic [COORD_BITS:0]     trial_y;
  logic                    ge_x;
  logic                    ge_y;
  logic [COORD_BITS-1:0]   rem_x_next;
  logic [COORD_BITS-1:0]   rem_y_next;
  logic signed [INC_W-1:0] q_x;
  logic signed [INC_W-1:0] q_y;
  logic [ACC_W-1:0]        rnd_x;
  logic [ACC_W-1:0]        rnd_y;

  assign uw = ucode(pc);

  // Handshake
  assign seg.ready  = (uw.op == OP_LATCH) && !rst;
  assign in_beat    = seg.valid && seg.ready;
  assign emit_fire  = (uw.op == OP_EMIT) && (!out_valid || pix.ready);
  assign last_out   = emit_fire && (count == steps);

  assign pix.valid      = out_valid;
  assign pix.pixel_x    = out_x;
  assign pix.pixel_y    = out_y;
  assign pix.last_pixel = out_last;

  // Evaluate jump condition
  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS:   cond_true = 1'b1;
      COND_IN_BEAT:  cond_true = in_beat;
      COND_ZERO_LEN: cond_true = (steps == '0);
      COND_DIV_DONE: cond_true = (div_cnt == '0);
      COND_LAST_OUT: cond_true = last_out;
      default:       cond_true = 1'b0;
    endcase
  end

  // Next program step
  always_comb begin
    if (cond_true) begin
      pc_next = uw.target;
    end else if (uw.hold) begin
      pc_next = pc;
    end else begin
      pc_next = pc + pc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_LATCH;
    end else begin
      pc <= pc_next;
    end
  end

  // Segment deltas
  assign adx = (seg.x_end > seg.x_start) ? (seg.x_end - seg.x_start)
                                         : (seg.x_start - seg.x_end);
  assign ady = (seg.y_end > seg.y_start) ? (seg.y_end - seg.y_start)
                                         : (seg.y_start - seg.y_end);

  // One restoring divide bit per lane
  always_comb begin
    trial_x    = {rem_x, dvd_x[DW-1]};
    trial_y    = {rem_y, dvd_y[DW-1]};
    ge_x       = (trial_x >= {1'b0, steps});
    ge_y       = (trial_y >= {1'b0, steps});
    rem_x_next = ge_x ? COORD_BITS'(trial_x - {1'b0, steps}) : trial_x[COORD_BITS-1:0];
    rem_y_next = ge_y ? COORD_BITS'(trial_y - {1'b0, steps}) : trial_y[COORD_BITS-1:0];
  end

  // Quotients fit in FRACTION_BITS+1 bits since |d| <= steps
  assign q_x = {1'b0, dvd_x[FRACTION_BITS:0]};
  assign q_y = {1'b0, dvd_y[FRACTION_BITS:0]};

  // Round half up
  assign rnd_x = acc_x + (ACC_W'(1) << (FRACTION_BITS - 1));
  assign rnd_y = acc_y + (ACC_W'(1) << (FRACTION_BITS - 1));

  // Datapath
  always_ff @(posedge clk) begin
    if (in_beat) begin
      steps   <= (adx > ady) ? adx : ady;
      neg_x   <= (seg.x_end < seg.x_start);
      neg_y   <= (seg.y_end < seg.y_start);
      dvd_x   <= {adx, FRACTION_BITS'(0)};
      dvd_y   <= {ady, FRACTION_BITS'(0)};
      rem_x   <= '0;
      rem_y   <= '0;
      div_cnt <= DIV_CNT_W'(DW - 1);
      acc_x   <= {seg.x_start, FRACTION_BITS'(0)};
      acc_y   <= {seg.y_start, FRACTION_BITS'(0)};
      count   <= '0;
    end
    if (uw.op == OP_DIV_STEP) begin
      dvd_x   <= {dvd_x[DW-2:0], ge_x};
      dvd_y   <= {dvd_y[DW-2:0], ge_y};
      rem_x   <= rem_x_next;
      rem_y   <= rem_y_next;
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
    if (uw.op == OP_DIV_STORE) begin
      inc_x <= neg_x ? -q_x : q_x;
      inc_y <= neg_y ? -q_y : q_y;
    end
    if (emit_fire) begin
      acc_x <= acc_x + ACC_W'(inc_x);
      acc_y <= acc_y + ACC_W'(inc_y);
      count <= count + COORD_BITS'(1);
    end
  end

  // Output register: load a pixel, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_x    <= rnd_x[FRACTION_BITS +: COORD_BITS];
      out_y    <= rnd_y[FRACTION_BITS +: COORD_BITS];
      out_last <= (count == steps);
    end
  end

`ifndef SYNTHESIS
  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    pc <= PC_EMIT)
    else $error("program counter left the program");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    (pc == PC_EMIT) |-> (count <= steps))
    else $error("pixel count ran past the step count");

  // The last divide step wraps the bit counter below zero
  a_div_complete: assert property (@(posedge clk) disable iff (rst)
    (pc == PC_DIV_STORE) |-> (div_cnt == '1 && rem_x < steps && rem_y < steps))
    else $error("divider stored before all quotient bits were done");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    last_out |=> (pc == PC_LATCH && out_valid && out_last))
    else $error("last pixel did not end the segment");
`endif

endmodule
